>>> hdl/qrlc_pkg.sv
// ============================================================================
// qrlc_pkg: shared types and constants of the reel length counter
// Field widths, register indexes, reset values and the pair decoding helper.
// ============================================================================
package qrlc_pkg;

  // Whole-rotation counter width; rotations saturate in its signed range
  localparam int ROT_W = 16;

  localparam int CPR_W   = 10;
  localparam int LPR_W   = 24;
  localparam int EDGE_W  = 11;
  localparam int LEN_W   = 23;
  localparam int ROT_OUT_W = 16;
  localparam int FRAC_W  = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  // Register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_CPR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LPR = 8'd1;

  localparam logic [CPR_W-1:0] CPR_RESET = 10'd204;
  localparam logic [LPR_W-1:0] LPR_RESET = 24'd63193;

  localparam logic signed [ROT_W-1:0] ROT_RESET = ROT_W'(2);
  localparam logic signed [ROT_W-1:0] ROT_MAX   = {1'b0, {(ROT_W-1){1'b1}}};
  localparam logic signed [ROT_W-1:0] ROT_MIN   = {1'b1, {(ROT_W-1){1'b0}}};

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Pair codes, (A << 1) | B
  localparam logic [1:0] PAIR_00 = 2'b00;
  localparam logic [1:0] PAIR_01 = 2'b01;
  localparam logic [1:0] PAIR_10 = 2'b10;
  localparam logic [1:0] PAIR_11 = 2'b11;

  // Step result handed from the decoder to the length stage
  typedef struct packed {
    logic                     moved;
    logic                     reverse;
    logic signed [EDGE_W-1:0] edge_count;
    logic signed [ROT_W-1:0]  rotations;
  } step_t;

  // Reverse successor of a pair: 11->10, 10->00, 00->01, 01->11
  function automatic logic [1:0] reverse_next(input logic [1:0] pair);
    logic [1:0] nxt;
    unique case (pair)
      PAIR_11: nxt = PAIR_10;
      PAIR_10: nxt = PAIR_00;
      PAIR_00: nxt = PAIR_01;
      default: nxt = PAIR_11;
    endcase
    return nxt;
  endfunction

endpackage

>>> hdl/quadrature_reel_length_counter_core.sv
// ============================================================================
// quadrature_reel_length_counter_core: quadrature reel line length counter
// Decodes encoder samples into edges and rotations and reports line length.
// ============================================================================
// Usage:
//   s_axis carries one encoder sample per transaction (tdata bit 0 = A,
//   bit 1 = B). m_axis returns one result transaction per sample, in order.
//   The cfg channel writes counts_per_rotation (index 0) and
//   length_per_rotation (index 1, Q8.16); other indexes are ignored. It is
//   always ready and should be written only while no sample is in flight.
// Timing:
//   Two register stages: the decoder state register, then the length
//   register after the 15 x 24 multiplier. m_axis_tvalid rises once its
//   sample has passed both registers; one sample is taken every cycle
//   while the output does not stall.
// Reset:
//   Previous pair low, edge count 0, rotations 2, direction forward, both
//   registers at their defaults; the pipeline is empty.
// Stall:
//   While m_axis_tready is low the output holds; one more sample may enter
//   the decoder stage, then s_axis_tready drops until the output drains.
// ============================================================================
module quadrature_reel_length_counter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [qrlc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [qrlc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: [0] chan_a, [1] chan_b, [7:2] zero
  input  logic [qrlc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: [0] moved, [1] reverse, [12:2] edge_count, [28:13] rotation_total,
  //        [51:29] line_length, [55:52] zero
  output logic [qrlc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  logic [qrlc_pkg::CPR_W-1:0]  cpr_q;
  logic [qrlc_pkg::LPR_W-1:0]  lpr_q;
  logic                        s1_valid_q;
  logic                        s2_ready;
  logic                        in_fire;
  qrlc_pkg::step_t             s1_step, out_step;
  logic [qrlc_pkg::LEN_W-1:0]  out_len;
  logic [qrlc_pkg::ROT_OUT_W-1:0] out_rot;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= qrlc_pkg::CPR_RESET;
      lpr_q <= qrlc_pkg::LPR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qrlc_pkg::CFG_CPR: cpr_q <= cfg_data_i[qrlc_pkg::CPR_W-1:0];
        qrlc_pkg::CFG_LPR: lpr_q <= cfg_data_i[qrlc_pkg::LPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one accepts when empty or when its content moves on
  assign s_axis_tready = !s1_valid_q || s2_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  qrlc_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (in_fire),
    .chan_a_i  (s_axis_tdata[0]),
    .chan_b_i  (s_axis_tdata[1]),
    .cpr_i     (cpr_q),
    .step_o    (s1_step)
  );

  qrlc_length u_length (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ready_o (s2_ready),
    .step_i  (s1_step),
    .lpr_i   (lpr_q),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .step_o  (out_step),
    .len_o   (out_len)
  );

  // Pack the result fields
  assign out_rot      = qrlc_pkg::ROT_OUT_W'(out_step.rotations);
  assign m_axis_tdata = {4'b0000, out_len, out_rot, out_step.edge_count,
                         out_step.reverse, out_step.moved};

  // An empty decoder stage never refuses a sample
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("input refused while pipeline stage empty");

  // Line length is zero for rotations below one
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_step.rotations[qrlc_pkg::ROT_W-1] ||
                      out_step.rotations == '0) |-> (out_len == '0))
    else $error("nonzero length with rotations below one");

  // A stalled stage one keeps its content until it moves on
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_step))
    else $error("stage one content lost during stall");

endmodule

>>> hdl/qrlc_decode.sv
// ============================================================================
// qrlc_decode: quadrature step decoder and rotation tracker
// Holds the previous pair, edge count, rotations and direction; these
// registers also form the first pipeline stage seen by the length stage.
// ============================================================================
module qrlc_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_en_i,
  input  logic                        chan_a_i,
  input  logic                        chan_b_i,
  input  logic [qrlc_pkg::CPR_W-1:0]  cpr_i,
  output qrlc_pkg::step_t             step_o
);

  localparam int EXT_W = qrlc_pkg::EDGE_W + 1;

  logic [1:0]                              pair;
  logic [1:0]                              prev_q, prev_d;
  logic signed [qrlc_pkg::EDGE_W-1:0]      edge_q, edge_d;
  logic signed [qrlc_pkg::ROT_W-1:0]       rot_q, rot_d;
  logic                                    dir_q, dir_d;
  logic                                    moved_q, moved_d;
  logic signed [EXT_W-1:0]                 edge_ext, edge_inc, edge_dec;
  logic signed [EXT_W-1:0]                 cpr_pos, cpr_neg;

  assign pair     = {chan_a_i, chan_b_i};
  assign edge_ext = EXT_W'(edge_q);
  assign edge_inc = edge_ext + EXT_W'(1);
  assign edge_dec = edge_ext - EXT_W'(1);
  assign cpr_pos  = signed'(EXT_W'(cpr_i));
  assign cpr_neg  = -cpr_pos;

  // Step the count on a change, wrap into rotations at the threshold
  always_comb begin
    prev_d  = pair;
    edge_d  = edge_q;
    rot_d   = rot_q;
    dir_d   = dir_q;
    moved_d = (pair != prev_q);
    if (moved_d) begin
      if (pair == qrlc_pkg::reverse_next(prev_q)) begin
        dir_d = 1'b1;
        if (edge_dec <= cpr_neg) begin
          edge_d = '0;
          if (rot_q != qrlc_pkg::ROT_MIN) rot_d = rot_q - qrlc_pkg::ROT_W'(1);
        end else begin
          edge_d = edge_dec[qrlc_pkg::EDGE_W-1:0];
        end
      end else begin
        dir_d = 1'b0;
        if (edge_inc >= cpr_pos) begin
          edge_d = '0;
          if (rot_q != qrlc_pkg::ROT_MAX) rot_d = rot_q + qrlc_pkg::ROT_W'(1);
        end else begin
          edge_d = edge_inc[qrlc_pkg::EDGE_W-1:0];
        end
      end
    end
  end

  // Advance the state on each accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= qrlc_pkg::PAIR_00;
      edge_q  <= '0;
      rot_q   <= qrlc_pkg::ROT_RESET;
      dir_q   <= 1'b0;
      moved_q <= 1'b0;
    end else if (step_en_i) begin
      prev_q  <= prev_d;
      edge_q  <= edge_d;
      rot_q   <= rot_d;
      dir_q   <= dir_d;
      moved_q <= moved_d;
    end
  end

  assign step_o.moved      = moved_q;
  assign step_o.reverse    = dir_q;
  assign step_o.edge_count = edge_q;
  assign step_o.rotations  = rot_q;

  // A sample equal to the previous pair leaves count and rotations alone
  a_still_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && (pair == prev_q) |=> $stable(edge_q) && $stable(rot_q) && !moved_q)
    else $error("count changed without movement");

  // A rotation step always clears the edge count
  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && (rot_d != rot_q) |=> (edge_q == '0))
    else $error("rotation stepped without clearing edge count");

endmodule

>>> hdl/qrlc_length.sv
// ============================================================================
// qrlc_length: line length stage and output register
// Multiplies rotations by length per rotation, drops the fraction, saturates
// and holds the finished result until the downstream side takes it.
// ============================================================================
module qrlc_length (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  qrlc_pkg::step_t             step_i,
  input  logic [qrlc_pkg::LPR_W-1:0]  lpr_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output qrlc_pkg::step_t             step_o,
  output logic [qrlc_pkg::LEN_W-1:0]  len_o
);

  localparam int MAG_W  = qrlc_pkg::ROT_W - 1;
  localparam int PROD_W = MAG_W + qrlc_pkg::LPR_W;
  localparam int SHR_W  = PROD_W - qrlc_pkg::FRAC_W;

  logic                            valid_q;
  qrlc_pkg::step_t                 step_q;
  logic [qrlc_pkg::LEN_W-1:0]      len_q, len_d;
  logic [MAG_W-1:0]                mag;
  logic [PROD_W-1:0]               prod;
  logic [SHR_W-1:0]                whole;
  logic                            positive;

  // Length is zero unless at least one whole rotation
  assign positive = !step_i.rotations[qrlc_pkg::ROT_W-1] && (step_i.rotations != '0);
  assign mag      = step_i.rotations[MAG_W-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(lpr_i);
  assign whole    = prod[PROD_W-1:qrlc_pkg::FRAC_W];

  always_comb begin
    if (!positive) begin
      len_d = '0;
    end else if (whole > SHR_W'(qrlc_pkg::LEN_MAX)) begin
      len_d = qrlc_pkg::LEN_MAX;
    end else begin
      len_d = qrlc_pkg::LEN_W'(whole);
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Load a new result whenever the output slot is free or being emptied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      step_q <= step_i;
      len_q  <= len_d;
    end
  end

  assign valid_o = valid_q;
  assign step_o  = step_q;
  assign len_o   = len_q;

endmodule

>>> tb/tb_quadrature_reel_length_counter_core.sv
// ============================================================================
// tb_quadrature_reel_length_counter_core: self-checking reel counter bench
// Drives encoder samples over the input stream and predicts every result in
// a behavioral model of the decoder. Each result is compared in order, field
// by field. The run covers directed direction and threshold cases, random
// encoder walks under three idle mixes, back pressure, and fast rotation
// runs at full length per rotation down through zero rotations.
// ============================================================================
`timescale 1ns / 100ps

module tb_quadrature_reel_length_counter_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int ROT_HI         = (1 <<< (qrlc_pkg::ROT_W - 1)) - 1;
  localparam int ROT_LO         = -ROT_HI - 1;
  localparam longint LEN_LIMIT  = (longint'(1) <<< qrlc_pkg::LEN_W) - 1;
  localparam logic [qrlc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
  localparam logic [qrlc_pkg::CFG_IDX_W-1:0] CFG_LAST  = 8'hFF;

  typedef struct packed {
    logic                               moved;
    logic                               reverse;
    logic [qrlc_pkg::EDGE_W-1:0]        edge_cnt;
    logic [qrlc_pkg::ROT_OUT_W-1:0]     rot_total;
    logic [qrlc_pkg::LEN_W-1:0]         line_len;
  } reel_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [qrlc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [qrlc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [qrlc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [qrlc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Predicted decoder state and register copies
  logic [1:0]  enc_pair = qrlc_pkg::PAIR_00;
  int          edge_acc = 0;
  int          rot_acc = 2;
  logic        dir_rev = 1'b0;
  int unsigned cpr_reg = qrlc_pkg::CPR_RESET;
  int unsigned lpr_reg = qrlc_pkg::LPR_RESET;

  reel_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int rot_up_steps = 0;
  int rot_down_steps = 0;
  int cfg_writes = 0;

  quadrature_reel_length_counter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Map a pair to its position on the quadrature cycle; the map is its own
  // inverse, so it also turns a position back into a pair
  function automatic logic [1:0] quad_phase(input logic [1:0] p);
    return {p[1], p[1] ^ p[0]};
  endfunction

  // Neighbor of a pair one step along the cycle; down is the reverse way
  function automatic logic [1:0] next_pair(input logic [1:0] p, input bit down);
    logic [1:0] ph;
    ph = quad_phase(p);
    ph = down ? ph + 2'd1 : ph - 2'd1;
    return quad_phase(ph);
  endfunction

  // Advance the predicted decoder by one sample and return its result
  function automatic reel_result_t advance_reel(input logic [1:0] pair);
    reel_result_t r;
    longint       len;
    r.moved = (pair != enc_pair);
    if (r.moved) begin
      if (pair == next_pair(enc_pair, 1'b1)) begin
        dir_rev = 1'b1;
        edge_acc--;
        if (edge_acc <= -int'(cpr_reg)) begin
          if (rot_acc > ROT_LO) begin
            rot_acc--;
          end
          rot_down_steps++;
          edge_acc = 0;
        end
      end else begin
        dir_rev = 1'b0;
        edge_acc++;
        if (edge_acc >= int'(cpr_reg)) begin
          if (rot_acc < ROT_HI) begin
            rot_acc++;
          end
          rot_up_steps++;
          edge_acc = 0;
        end
      end
    end
    enc_pair = pair;
    len = 0;
    if (rot_acc >= 1) begin
      len = (longint'(rot_acc) * longint'(lpr_reg)) >>> qrlc_pkg::FRAC_W;
      if (len > LEN_LIMIT) begin
        len = LEN_LIMIT;
      end
    end
    r.reverse = dir_rev;
    r.edge_cnt = qrlc_pkg::EDGE_W'(edge_acc);
    r.rot_total = qrlc_pkg::ROT_OUT_W'(rot_acc);
    r.line_len = qrlc_pkg::LEN_W'(len);
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Offer one sample (pair = {A, B}) and predict its result once accepted
  task automatic send_sample(input logic [1:0] pair);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(qrlc_pkg::IN_DATA_W-2){1'b0}}, pair[0], pair[1]};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    pending_results.push_back(advance_reel(pair));
    samples_sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register while the pipeline is empty
  task automatic write_reg(input logic [qrlc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qrlc_pkg::CFG_DATA_W-1:0] data);
    bit taken;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    if (idx == qrlc_pkg::CFG_CPR) begin
      cpr_reg = data[qrlc_pkg::CPR_W-1:0];
    end else if (idx == qrlc_pkg::CFG_LPR) begin
      lpr_reg = data[qrlc_pkg::LPR_W-1:0];
    end
    cfg_writes++;
  endtask

  task automatic walk(input bit down, input int steps);
    for (int i = 0; i < steps; i++) begin
      send_sample(next_pair(enc_pair, down));
    end
  endtask

  // Reset values: samples with no movement show rotations 2 at the default length
  task automatic test_reset_defaults();
    send_sample(qrlc_pkg::PAIR_00);
    send_sample(qrlc_pkg::PAIR_00);
  endtask

  // Forward cycle, reverse cycle, jumps of both channels and a hold
  task automatic test_direction_decode();
    send_sample(qrlc_pkg::PAIR_10);
    send_sample(qrlc_pkg::PAIR_11);
    send_sample(qrlc_pkg::PAIR_01);
    send_sample(qrlc_pkg::PAIR_00);
    send_sample(qrlc_pkg::PAIR_01);
    send_sample(qrlc_pkg::PAIR_11);
    send_sample(qrlc_pkg::PAIR_10);
    send_sample(qrlc_pkg::PAIR_00);
    send_sample(qrlc_pkg::PAIR_11);
    send_sample(qrlc_pkg::PAIR_00);
    send_sample(qrlc_pkg::PAIR_01);
    send_sample(qrlc_pkg::PAIR_10);
    send_sample(qrlc_pkg::PAIR_10);
  endtask

  // Thresholds, a lowered threshold, zero threshold, masking, unused indexes
  task automatic test_rotation_threshold();
    write_reg(qrlc_pkg::CFG_CPR, 24'hFFFC05);
    write_reg(CFG_SPARE, 24'h000001);
    write_reg(CFG_LAST, 24'hFFFFFF);
    walk(1'b0, 4);
    write_reg(qrlc_pkg::CFG_CPR, 24'd2);
    walk(1'b0, 1);
    walk(1'b1, 1);
    write_reg(qrlc_pkg::CFG_CPR, 24'd1);
    walk(1'b1, 1);
    write_reg(qrlc_pkg::CFG_CPR, 24'd0);
    walk(1'b0, 1);
    walk(1'b1, 1);
    write_reg(qrlc_pkg::CFG_LPR, 24'd0);
    send_sample(enc_pair);
    write_reg(qrlc_pkg::CFG_LPR, 24'hFFFFFF);
    send_sample(enc_pair);
  endtask

  // Random encoder walks with occasional holds, jumps and noise
  task automatic test_random_walk(input int tx_pct, input int rx_pct, input int count);
    bit         walk_down;
    int         pick;
    logic [1:0] pair;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    walk_down = $urandom_range(1);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        pick = $urandom_range(9);
        write_reg(qrlc_pkg::CFG_CPR, {14'($urandom()),
                            (pick == 0) ? 10'd0 :
                            (pick == 1) ? 10'd1023 : 10'($urandom_range(1, 8))});
        write_reg(qrlc_pkg::CFG_LPR, 24'($urandom()));
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        pair = 2'($urandom());
      end else if (pick < 12) begin
        pair = enc_pair;
      end else if (pick < 18) begin
        pair = ~enc_pair;
      end else begin
        if ($urandom_range(9) == 0) begin
          walk_down = ~walk_down;
        end
        pair = next_pair(enc_pair, walk_down);
      end
      send_sample(pair);
    end
  endtask

  // Long receiver hold-off that fills the pipe, a sender pause, then random receiver stalls
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(qrlc_pkg::CFG_CPR, 24'd3);
    @(negedge clk_i);
    hold_left = 250;
    @(posedge clk_i);
    walk(1'b0, 30);
    wait_drained();
    recv_idle_pct = 50;
    walk(1'b1, 30);
  endtask

  // Rotation step on every move at full length per rotation, then down below zero
  task automatic test_long_runs();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(qrlc_pkg::CFG_CPR, 24'd0);
    write_reg(qrlc_pkg::CFG_LPR, 24'hFFFFFF);
    walk(1'b0, 12);
    walk(1'b1, 24);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(negedge clk_i) begin : check_result
    reel_result_t got;
    reel_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.moved = m_axis_tdata[0];
      got.reverse = m_axis_tdata[1];
      got.edge_cnt = m_axis_tdata[12:2];
      got.rot_total = m_axis_tdata[28:13];
      got.line_len = m_axis_tdata[51:29];
      if (pending_results.size() == 0) begin
        note_mismatch("result with no sample pending");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          note_mismatch($sformatf({"expected moved=%0d rev=%0d edge=%0d rot=%0d len=%0d,",
                                   " got moved=%0d rev=%0d edge=%0d rot=%0d len=%0d"},
                                  want.moved, want.reverse, $signed(want.edge_cnt),
                                  $signed(want.rot_total), want.line_len,
                                  got.moved, got.reverse, $signed(got.edge_cnt),
                                  $signed(got.rot_total), got.line_len));
        end
      end
    end
  end

  // Watchdog: count cycles without any transaction
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 68;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_direction_decode();
    test_rotation_threshold();
    test_random_walk(32, 68, 100);
    test_random_walk(68, 32, 100);
    test_random_walk(0, 0, 100);
    test_back_pressure();
    test_long_runs();

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d samples and %0d results, %0d register writes,",
             samples_sent, results_checked, cfg_writes);
    $display("  %0d rotation steps up and %0d down, with holds, jumps and stalls.",
             rot_up_steps, rot_down_steps);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> quadrature_reel_length_counter_core.f
hdl/qrlc_pkg.sv
hdl/qrlc_decode.sv
hdl/qrlc_length.sv
hdl/quadrature_reel_length_counter_core.sv
tb/tb_quadrature_reel_length_counter_core.sv
